@@ rtl/websocket_frame_parser_assert.svh @@
// Assertion macros shared by the websocket frame parser RTL.
// Each macro places one labelled concurrent assertion, clocked on the rising
// edge and held off while the active-low reset is asserted.
`ifndef WEBSOCKET_FRAME_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define WFP_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("websocket frame parser: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define WFP_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("websocket frame parser: next-cycle check failed");

`endif

@@ rtl/wfp_pkg.sv @@
// ----------------------------------------------------------------------------
// wfp_pkg
// Types and constants shared by the websocket frame parser modules.
// ----------------------------------------------------------------------------
package wfp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8176;

    // Header byte fields and length codes
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [2:0] KEY_BYTES      = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  opcode;
        logic [7:0]  payload_byte;
        logic [31:0] frame_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic res_valid;
        logic stuck;
    } dec_status_t;

endpackage

@@ rtl/wfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// wfp_in_stage
// Input register: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module wfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

@@ rtl/wfp_decoder.sv @@
// ----------------------------------------------------------------------------
// wfp_decoder
// Frame state machine: walks header, extended length, mask key and payload,
// one byte per take, and forms the result for that byte.
// ----------------------------------------------------------------------------
module wfp_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    output wfp_pkg::result_t     res,
    output wfp_pkg::dec_status_t status
);

    import wfp_pkg::*;

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_STUCK   = 3'd5;

    logic [31:0] max_payload_reg;
    logic [2:0]  phase_reg,       phase_next;
    logic [3:0]  opcode_reg,      opcode_next;
    logic        mask_on_reg,     mask_on_next;
    logic [3:0]  len_left_reg,    len_left_next;
    logic [63:0] decl_len_reg,    decl_len_next;
    logic [31:0] key_reg,         key_next;
    logic [2:0]  key_left_reg,    key_left_next;
    logic [31:0] pay_left_reg,    pay_left_next;
    logic [1:0]  key_pos_reg,     key_pos_next;

    logic        res_valid;
    logic        len_done;
    logic        hdr_go;
    logic        over_limit;
    logic        pay_last;
    logic [7:0]  key_byte;
    logic [31:0] hdr_len;

    always_comb begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        mask_on_next  = mask_on_reg;
        len_left_next = len_left_reg;
        decl_len_next = decl_len_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        pay_left_next = pay_left_reg;
        key_pos_next  = key_pos_reg;
        res           = '0;
        res.opcode    = opcode_reg;
        res_valid     = 1'b0;
        len_done      = 1'b0;
        hdr_go        = 1'b0;
        pay_last      = (pay_left_reg <= 32'd1);

        case (phase_reg)
            PH_BYTE0: begin
                opcode_next = rx_byte[3:0];
                phase_next  = PH_BYTE1;
            end
            PH_BYTE1: begin
                mask_on_next = rx_byte[7];
                if (rx_byte[6:0] == LEN_CODE_EXT16) begin
                    len_left_next = EXT16_BYTES;
                    decl_len_next = '0;
                    phase_next    = PH_EXTLEN;
                end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
                    len_left_next = EXT64_BYTES;
                    decl_len_next = '0;
                    phase_next    = PH_EXTLEN;
                end else begin
                    decl_len_next = {57'd0, rx_byte[6:0]};
                    len_done      = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // big-endian: shift in below the bytes already held
                decl_len_next = {decl_len_reg[55:0], rx_byte};
                len_left_next = len_left_reg - 4'd1;
                len_done      = (len_left_next == 4'd0);
            end
            PH_KEY: begin
                key_next      = {key_reg[23:0], rx_byte};
                key_left_next = key_left_reg - 3'd1;
                hdr_go        = (key_left_next == 3'd0);
            end
            PH_PAYLOAD: begin
                key_pos_next     = key_pos_reg + 2'd1;
                pay_left_next    = pay_last ? 32'd0 : pay_left_reg - 32'd1;
                if (pay_last) begin
                    phase_next = PH_BYTE0;
                end
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte ^ key_byte;
                res.last         = pay_last;
            end
            PH_STUCK: begin
                // drop everything until reset
            end
            default: begin
                phase_next = PH_STUCK;
            end
        endcase

        over_limit = (|decl_len_next[63:32]) || (decl_len_next[31:0] > max_payload_reg);

        if (len_done) begin
            if (over_limit) begin
                phase_next = PH_STUCK;
                res_valid  = 1'b1;
                res.kind   = KIND_ERROR;
                res.last   = 1'b1;
            end else if (mask_on_next) begin
                key_left_next = KEY_BYTES;
                key_next      = '0;
                phase_next    = PH_KEY;
            end else begin
                key_next = '0;
                hdr_go   = 1'b1;
            end
        end

        hdr_len = decl_len_next[31:0];
        if (hdr_go) begin
            pay_left_next    = hdr_len;
            key_pos_next     = 2'd0;
            phase_next       = (hdr_len == 32'd0) ? PH_BYTE0 : PH_PAYLOAD;
            res_valid        = 1'b1;
            res.kind         = KIND_HEADER;
            res.frame_length = hdr_len;
            res.last         = (hdr_len == 32'd0);
        end
    end

    assign status.res_valid = res_valid;
    assign status.stuck     = (phase_reg == PH_STUCK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            max_payload_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BYTE0;
            opcode_reg   <= '0;
            mask_on_reg  <= 1'b0;
            len_left_reg <= '0;
            decl_len_reg <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            pay_left_reg <= '0;
            key_pos_reg  <= '0;
        end else if (take) begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            mask_on_reg  <= mask_on_next;
            len_left_reg <= len_left_next;
            decl_len_reg <= decl_len_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            pay_left_reg <= pay_left_next;
            key_pos_reg  <= key_pos_next;
        end
    end

endmodule

@@ rtl/wfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// wfp_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wfp_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  wfp_pkg::result_t res_in,
    output logic             can_take,
    output logic             m_valid,
    input  logic             m_ready,
    output wfp_pkg::result_t res_out
);

    import wfp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

@@ rtl/websocket_frame_parser.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Receive-side WebSocket frame decoder, one byte per item.
// ----------------------------------------------------------------------------
// Bytes of the frame stream enter on the s_ channel (s_valid / s_ready,
// s_rx_byte). Each accepted byte yields at most one result on the m_ channel:
// a header (opcode, frame length) once the length and any mask key are in,
// one unmasked item per payload byte with m_last on the final one, or a
// single error item when the length exceeds max_payload. After an error
// every byte is dropped until reset.
// The cfg_ channel writes max_payload; write it only while the parser idles.
// Timing: the accepted byte is held in the input register; when the decoder
// takes it, the result register loads any result, and m_valid rises from it.
// Throughput: one byte per cycle while the result register is free or m_ready
// is high; a held result stalls the flow.
// Reset (aresetn, synchronous, active low) returns to the first header byte,
// empties both registers and restores max_payload to 8176.
// While m_ready is low a held result blocks the decoder; at most one more
// byte is taken into the input register, then s_ready drops.
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_assert.svh"

module websocket_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_opcode,
    output logic [7:0]  m_payload_byte,
    output logic [31:0] m_frame_length,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_max_payload
);

    import wfp_pkg::*;

    logic        byte_valid;
    logic [7:0]  rx_byte;
    logic        take;
    logic        can_take;
    logic        load;
    result_t     dec_res;
    result_t     out_res;
    dec_status_t dec_status;

    assign cfg_ready = 1'b1;
    assign take      = byte_valid && can_take;
    assign load      = take && dec_status.res_valid;

    wfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    wfp_decoder u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_max_payload),
        .take     (take),
        .rx_byte  (rx_byte),
        .res      (dec_res),
        .status   (dec_status)
    );

    wfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res_in   (dec_res),
        .can_take (can_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (out_res)
    );

    assign m_kind         = out_res.kind;
    assign m_opcode       = out_res.opcode;
    assign m_payload_byte = out_res.payload_byte;
    assign m_frame_length = out_res.frame_length;
    assign m_last         = out_res.last;

    `WFP_ASSERT_NEXT(a_stuck_holds, aclk, aresetn, dec_status.stuck, dec_status.stuck)
    `WFP_ASSERT_SAME(a_stuck_silent, aclk, aresetn, dec_status.stuck, !dec_status.res_valid)
    `WFP_ASSERT_SAME(a_error_last, aclk, aresetn, m_valid && (m_kind == KIND_ERROR), m_last && (m_frame_length == 32'd0))
    `WFP_ASSERT_SAME(a_payload_nolen, aclk, aresetn, m_valid && (m_kind == KIND_PAYLOAD), m_frame_length == 32'd0)

endmodule

@@ verif/websocket_frame_parser_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_checker
// Watches the byte, result and register channels of the frame parser, decodes
// every accepted byte with its own frame decoder and compares each result item
// field by field with the oldest decoded result still owed.
// ----------------------------------------------------------------------------
module websocket_frame_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [3:0]  m_opcode,
    input  logic [7:0]  m_payload_byte,
    input  logic [31:0] m_frame_length,
    input  logic        m_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_max_payload,
    output int          fail_count,
    output int          results_owed
);

    import wfp_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_OPCODE,
        AWAIT_LENGTH,
        AWAIT_EXT_LENGTH,
        AWAIT_KEY,
        IN_PAYLOAD,
        LOCKED_OUT
    } parse_step_e;

    parse_step_e step;
    logic [31:0] length_limit;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [3:0]  length_bytes_due;
    logic [63:0] length_acc;
    logic [31:0] key_word;
    logic [2:0]  key_bytes_due;
    logic [31:0] payload_due;
    logic [1:0]  key_lane;
    logic        locked;

    result_t owed_results[$];

    initial begin
        fail_count   = 0;
        results_owed = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        fail_count++;
    endtask

    // Header item; move on to the payload, or straight to the next frame.
    function automatic bit open_frame(output result_t res);
        logic [31:0] len32;
        len32            = length_acc[31:0];
        res              = '0;
        res.kind         = KIND_HEADER;
        res.opcode       = frame_opcode;
        res.frame_length = len32;
        res.last         = (len32 == 32'd0);
        payload_due      = len32;
        key_lane         = 2'd0;
        step             = (len32 == 32'd0) ? AWAIT_OPCODE : IN_PAYLOAD;
        return 1'b1;
    endfunction

    // Length complete: check against the limit, then take the key or open.
    function automatic bit close_length(output result_t res);
        res = '0;
        if (length_acc > {32'd0, length_limit}) begin
            locked     = 1'b1;
            step       = LOCKED_OUT;
            res.kind   = KIND_ERROR;
            res.opcode = frame_opcode;
            res.last   = 1'b1;
            return 1'b1;
        end
        key_word = 32'd0;
        if (masked) begin
            key_bytes_due = KEY_BYTES;
            step          = AWAIT_KEY;
            return 1'b0;
        end
        return open_frame(res);
    endfunction

    function automatic bit decode_rx_byte(input logic [7:0] rx, output result_t res);
        logic [7:0] key_byte;
        logic       final_byte;
        res = '0;
        if (locked)
            return 1'b0;
        case (step)
            AWAIT_OPCODE: begin
                frame_opcode = rx[3:0];
                step         = AWAIT_LENGTH;
                return 1'b0;
            end
            AWAIT_LENGTH: begin
                masked     = rx[7];
                length_acc = 64'd0;
                if (rx[6:0] == LEN_CODE_EXT16 || rx[6:0] == LEN_CODE_EXT64) begin
                    length_bytes_due = (rx[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES
                                                                   : EXT64_BYTES;
                    step = AWAIT_EXT_LENGTH;
                    return 1'b0;
                end
                length_acc = {57'd0, rx[6:0]};
                return close_length(res);
            end
            AWAIT_EXT_LENGTH: begin
                length_acc       = {length_acc[55:0], rx};
                length_bytes_due = length_bytes_due - 4'd1;
                if (length_bytes_due != 4'd0)
                    return 1'b0;
                return close_length(res);
            end
            AWAIT_KEY: begin
                key_word      = {key_word[23:0], rx};
                key_bytes_due = key_bytes_due - 3'd1;
                if (key_bytes_due != 3'd0)
                    return 1'b0;
                return open_frame(res);
            end
            IN_PAYLOAD: begin
                // First key byte received unmasks payload bytes 0, 4, 8 ...
                key_byte    = key_word[31 - 8 * key_lane -: 8];
                key_lane    = key_lane + 2'd1;
                final_byte  = (payload_due <= 32'd1);
                payload_due = final_byte ? 32'd0 : payload_due - 32'd1;
                if (final_byte)
                    step = AWAIT_OPCODE;
                res.kind         = KIND_PAYLOAD;
                res.opcode       = frame_opcode;
                res.payload_byte = rx ^ key_byte;
                res.last         = final_byte;
                return 1'b1;
            end
            default: begin
                locked = 1'b1;
                step   = LOCKED_OUT;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        result_t decoded;
        if (!aresetn) begin
            step             = AWAIT_OPCODE;
            length_limit     = MAX_PAYLOAD_RESET;
            frame_opcode     = 4'd0;
            masked           = 1'b0;
            length_bytes_due = 4'd0;
            length_acc       = 64'd0;
            key_word         = 32'd0;
            key_bytes_due    = 3'd0;
            payload_due      = 32'd0;
            key_lane         = 2'd0;
            locked           = 1'b0;
            owed_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                length_limit = cfg_max_payload;
            if (m_valid && m_ready) begin
                seen.kind         = m_kind;
                seen.opcode       = m_opcode;
                seen.payload_byte = m_payload_byte;
                seen.frame_length = m_frame_length;
                seen.last         = m_last;
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected item", 32'(seen), 32'd0);
                end else begin
                    want = owed_results.pop_front();
                    if (seen.kind !== want.kind)
                        report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
                    if (seen.opcode !== want.opcode)
                        report_mismatch("opcode", 32'(seen.opcode), 32'(want.opcode));
                    if (seen.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", 32'(seen.payload_byte),
                                        32'(want.payload_byte));
                    if (seen.frame_length !== want.frame_length)
                        report_mismatch("frame_length", seen.frame_length,
                                        want.frame_length);
                    if (seen.last !== want.last)
                        report_mismatch("last", 32'(seen.last), 32'(want.last));
                end
            end
            if (s_valid && s_ready) begin
                if (decode_rx_byte(s_rx_byte, decoded))
                    owed_results.push_back(decoded);
            end
        end
        results_owed = owed_results.size();
    end

endmodule

@@ verif/websocket_frame_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_parser_test
// Feeds the frame parser a stream of WebSocket frames: a few hand-built ones,
// then random frames of every length encoding, masked and unmasked, under
// several length limits, with random gaps and back-pressure. Ends with an
// over-limit frame and a tail of bytes that must be dropped.
// ----------------------------------------------------------------------------
module websocket_frame_parser_test;
    import wfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 6;

    localparam int ENC_SHORT = 0;
    localparam int ENC_EXT16 = 1;
    localparam int ENC_EXT64 = 2;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte       = 8'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_opcode;
    logic [7:0]  m_payload_byte;
    logic [31:0] m_frame_length;
    logic        m_last;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_max_payload = 32'd0;

    int fail_count;
    int results_owed;

    int          bytes_sent   = 0;
    bit          gaps_on      = 1'b1;
    logic [31:0] length_limit = MAX_PAYLOAD_RESET;
    int          stall_left   = 0;
    int          calm_left    = 0;
    int          quiet_cycles = 0;

    // Empty frame, empty masked frame, masked frame wrapping the key,
    // then a 16-bit extended length.
    logic [7:0] opening_bytes [25] = '{
        8'h81, 8'h00,
        8'h8F, 8'h80, 8'hA1, 8'hB2, 8'hC3, 8'hD4,
        8'h02, 8'h85, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h0F,
        8'hF0, 8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00
    };

    always #5 aclk = ~aclk;

    websocket_frame_parser i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_opcode        (m_opcode),
        .m_payload_byte  (m_payload_byte),
        .m_frame_length  (m_frame_length),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_max_payload (cfg_max_payload)
    );

    websocket_frame_parser_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_opcode        (m_opcode),
        .m_payload_byte  (m_payload_byte),
        .m_frame_length  (m_frame_length),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_max_payload (cfg_max_payload),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    // Result side back-pressure: calm stretches, short and long stalls.
    always @(negedge aclk) begin
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                calm_left = $urandom_range(30, 200);
            else if (pick < 20)
                stall_left = $urandom_range(0, 3);
            else if (pick < 24)
                stall_left = $urandom_range(10, 40);
            m_ready <= (pick < 4 || pick >= 24);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int pick;
        if (!gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Called and returns at a falling edge; leaves valid high for the next item.
    task automatic push_byte(input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every owed result is out and the pipe is empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_valid       <= 1'b1;
        cfg_max_payload <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid    <= 1'b0;
        length_limit  = value;
    endtask

    task automatic send_frame(input bit opcode_sent);
        logic [31:0] len;
        logic [63:0] len64;
        logic [6:0]  code;
        bit          mask_bit;
        int          enc;
        int          pick;
        int          i;
        gaps_on = ($urandom_range(0, 3) != 0);
        if (!opcode_sent)
            push_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(0, 16);
        else if (pick < 90)
            len = $urandom_range(17, 125);
        else
            len = $urandom_range(126, 300);
        if (len > length_limit)
            len = length_limit;
        pick = $urandom_range(0, 99);
        if (len <= 32'd125 && pick < 70)
            enc = ENC_SHORT;
        else
            enc = pick[0] ? ENC_EXT16 : ENC_EXT64;
        mask_bit = 1'($urandom_range(0, 1));
        code = (enc == ENC_SHORT) ? len[6:0]
             : (enc == ENC_EXT16) ? LEN_CODE_EXT16 : LEN_CODE_EXT64;
        push_byte({mask_bit, code});
        len64 = {32'd0, len};
        if (enc != ENC_SHORT) begin
            for (i = (enc == ENC_EXT16) ? 1 : 7; i >= 0; i--)
                push_byte(len64[8 * i +: 8]);
        end
        if (mask_bit) begin
            repeat (4) push_byte(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_frames(input int byte_target);
        while (bytes_sent < byte_target)
            send_frame(1'b0);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_bytes[i])
            push_byte(opening_bytes[i]);
        settle();

        write_limit(32'hFFFF_FFFF);
        run_frames(650);
        settle();

        // Only empty frames fit under a zero limit.
        write_limit(32'd0);
        run_frames(760);
        settle();

        write_limit($urandom_range(1, 400));
        run_frames(1050);
        // Change the limit between the opcode byte and the length.
        push_byte(8'($urandom_range(0, 255)));
        settle();
        write_limit($urandom_range(0, 300));
        send_frame(1'b1);
        run_frames(1200);
        settle();

        write_limit(MAX_PAYLOAD_RESET);
        run_frames(1420);
        settle();

        // Over-limit frame with the reserved top length bit set, then the
        // parser must drop everything.
        write_limit($urandom);
        gaps_on = 1'b1;
        push_byte(8'($urandom_range(0, 255)));
        push_byte({1'($urandom_range(0, 1)), LEN_CODE_EXT64});
        push_byte(8'h80 | 8'($urandom_range(0, 255)));
        repeat (7) push_byte(8'($urandom_range(0, 255)));
        repeat (30) push_byte(8'($urandom_range(0, 255)));
        settle();
        repeat (10) @(negedge aclk);

        if (fail_count == 0 && results_owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wfp_pkg.sv
rtl/wfp_in_stage.sv
rtl/wfp_decoder.sv
rtl/wfp_out_stage.sv
rtl/websocket_frame_parser.sv
verif/websocket_frame_parser_checker.sv
verif/websocket_frame_parser_test.sv
